// ===== sv/tfu_pkg.sv =====
`timescale 1ns / 1ps

package tfu_pkg;

    // Input beat: a texel to convert or a palette entry to load.
    typedef struct packed {
        logic        operation;
        logic [31:0] texel_word;
        logic [7:0]  palette_slot;
        logic [31:0] palette_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lane_zero;
        logic [7:0] lane_one;
        logic [7:0] lane_two;
        logic [7:0] lane_three;
        logic [3:0] lanes_written;
    } t_out_item;

    // Live configuration; lane index 0 is red, then green, blue, alpha.
    typedef struct packed {
        logic [2:0]      raster_format;
        logic [1:0]      palette_mode;
        logic            alpha_present;
        logic [3:0][2:0] lane;
    } t_cfg;

    typedef logic [3:0][31:0] t_mask_set;
    typedef logic [3:0][4:0]  t_shift_set;
    typedef logic [3:0][7:0]  t_chan_set;

    localparam logic OP_CONVERT   = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    localparam logic [1:0] PAL_DIRECT = 2'd0;
    localparam logic [1:0] PAL_IDX4   = 2'd1;
    localparam logic [1:0] PAL_IDX8   = 2'd2;

    localparam logic [2:0] FMT_A1R5G5B5 = 3'd0;
    localparam logic [2:0] FMT_B8G8R8   = 3'd1;
    localparam logic [2:0] FMT_B8G8R8A8 = 3'd2;
    localparam logic [2:0] FMT_R4G4B4A4 = 3'd3;
    localparam logic [2:0] FMT_R5G5B5   = 3'd4;
    localparam logic [2:0] FMT_R5G6B5   = 3'd5;
    localparam logic [2:0] FMT_LUM8     = 3'd6;

    localparam logic [2:0] CFG_RASTER_FORMAT = 3'd0;
    localparam logic [2:0] CFG_PALETTE_MODE  = 3'd1;
    localparam logic [2:0] CFG_ALPHA_PRESENT = 3'd2;
    localparam logic [2:0] CFG_RED_LANE      = 3'd3;
    localparam logic [2:0] CFG_GREEN_LANE    = 3'd4;
    localparam logic [2:0] CFG_BLUE_LANE     = 3'd5;
    localparam logic [2:0] CFG_ALPHA_LANE    = 3'd6;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // Palette words hold one channel per byte.
    function automatic t_mask_set pal_masks();
        t_mask_set m;
        m[0] = 32'h0000_00FF;
        m[1] = 32'h0000_FF00;
        m[2] = 32'h00FF_0000;
        m[3] = 32'hFF00_0000;
        return m;
    endfunction

    function automatic t_shift_set pal_shifts();
        t_shift_set s;
        s[0] = 5'd0;
        s[1] = 5'd8;
        s[2] = 5'd16;
        s[3] = 5'd24;
        return s;
    endfunction

    // Channel masks per raster format, in the order red, green, blue, alpha.
    function automatic t_mask_set fmt_masks(input logic [2:0] fmt);
        t_mask_set m;
        m = '0;
        unique case (fmt)
            FMT_A1R5G5B5: begin
                m[0] = 32'h0000_003E; m[1] = 32'h0000_07C0;
                m[2] = 32'h0000_F800; m[3] = 32'h0000_0001;
            end
            FMT_B8G8R8: begin
                m[0] = 32'h00FF_0000; m[1] = 32'h0000_FF00;
                m[2] = 32'h0000_00FF; m[3] = 32'h0000_0000;
            end
            FMT_B8G8R8A8: begin
                m[0] = 32'h00FF_0000; m[1] = 32'h0000_FF00;
                m[2] = 32'h0000_00FF; m[3] = 32'hFF00_0000;
            end
            FMT_R4G4B4A4: begin
                m[0] = 32'h0000_000F; m[1] = 32'h0000_00F0;
                m[2] = 32'h0000_0F00; m[3] = 32'h0000_F000;
            end
            FMT_R5G5B5: begin
                m[0] = 32'h0000_001F; m[1] = 32'h0000_03E0;
                m[2] = 32'h0000_7C00; m[3] = 32'h0000_0000;
            end
            FMT_R5G6B5: begin
                m[0] = 32'h0000_001F; m[1] = 32'h0000_07E0;
                m[2] = 32'h0000_F800; m[3] = 32'h0000_0000;
            end
            FMT_LUM8: begin
                m[0] = 32'h0000_00FF; m[1] = 32'h0000_00FF;
                m[2] = 32'h0000_00FF; m[3] = 32'h0000_00FF;
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

    // Position of the lowest set bit of each mask; zero for an empty mask.
    function automatic t_shift_set fmt_shifts(input logic [2:0] fmt);
        t_shift_set s;
        s = '0;
        unique case (fmt)
            FMT_A1R5G5B5: begin
                s[0] = 5'd1;  s[1] = 5'd6;  s[2] = 5'd11; s[3] = 5'd0;
            end
            FMT_B8G8R8: begin
                s[0] = 5'd16; s[1] = 5'd8;  s[2] = 5'd0;  s[3] = 5'd0;
            end
            FMT_B8G8R8A8: begin
                s[0] = 5'd16; s[1] = 5'd8;  s[2] = 5'd0;  s[3] = 5'd24;
            end
            FMT_R4G4B4A4: begin
                s[0] = 5'd0;  s[1] = 5'd4;  s[2] = 5'd8;  s[3] = 5'd12;
            end
            FMT_R5G5B5: begin
                s[0] = 5'd0;  s[1] = 5'd5;  s[2] = 5'd10; s[3] = 5'd0;
            end
            FMT_R5G6B5: begin
                s[0] = 5'd0;  s[1] = 5'd5;  s[2] = 5'd11; s[3] = 5'd0;
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ===== sv/tfu_ram.sv =====
`timescale 1ns / 1ps

module tfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tfu_chan_stage.sv =====
`timescale 1ns / 1ps

module tfu_chan_stage
    import tfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [31:0] i_texel,
    input  logic        i_pal,
    input  logic        i_oor,
    input  logic [31:0] i_rdata,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output t_chan_set   o_ch
);

    logic        r_valid;
    t_chan_set   r_ch;
    t_chan_set   n_ch;
    logic [31:0] w_pixel;
    t_mask_set   w_mask;
    t_shift_set  w_shift;

    always_comb begin
        // An index past the palette depth reads as zero.
        w_pixel = i_pal ? (i_oor ? 32'd0 : i_rdata) : i_texel;
        w_mask  = i_pal ? pal_masks()  : fmt_masks(i_cfg.raster_format);
        w_shift = i_pal ? pal_shifts() : fmt_shifts(i_cfg.raster_format);
        for (int c = 0; c < 4; c++) begin
            n_ch[c] = 8'((w_pixel & w_mask[c]) >> w_shift[c]);
        end
        if (!i_cfg.alpha_present) begin
            n_ch[3] = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_ch <= n_ch;
        end
    end

    assign o_valid = r_valid;
    assign o_ch    = r_ch;

endmodule

// ===== sv/tfu_lane_stage.sv =====
`timescale 1ns / 1ps

module tfu_lane_stage
    import tfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_chan_set i_ch,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_out_item o_out
);

    logic            r_valid;
    logic [3:0][7:0] r_bytes;
    logic [3:0]      r_written;
    logic [3:0][7:0] n_bytes;
    logic [3:0]      n_written;

    // Channels are placed in order, so a later channel wins a shared lane.
    // A lane value with the top bit set (4 to 7) places nothing.
    always_comb begin
        n_bytes   = '0;
        n_written = '0;
        for (int c = 0; c < 4; c++) begin
            if (!i_cfg.lane[c][2]) begin
                n_bytes[i_cfg.lane[c][1:0]]   = i_ch[c];
                n_written[i_cfg.lane[c][1:0]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_bytes   <= n_bytes;
            r_written <= n_written;
        end
    end

    assign o_valid             = r_valid;
    assign o_out.lane_zero     = r_bytes[0];
    assign o_out.lane_one      = r_bytes[1];
    assign o_out.lane_two      = r_bytes[2];
    assign o_out.lane_three    = r_bytes[3];
    assign o_out.lanes_written = r_written;

endmodule

// ===== sv/texel_format_unpacker.sv =====
`timescale 1ns / 1ps
// A texel beat passes the palette read (alongside the first stage), channel extraction
// and lane placement registers, in that order, before it appears on o_out.
// Throughput: one beat per cycle; the three stages stall together only when the
// output register holds a beat that is not taken. Palette writes give no result.
// Reset clears the valid bits and loads the configuration defaults; palette
// contents are undefined until written.

module texel_format_unpacker
    import tfu_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data
);

    localparam int         AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    t_cfg        r_cfg;
    logic        w_adv;
    logic        w_accept;
    logic        w_pal_sel;
    logic [7:0]  w_idx;
    logic        w_pal_we;

    logic        r1_valid;
    logic [31:0] r1_texel;
    logic        r1_pal;
    logic        r1_oor;
    logic [31:0] w_rdata;

    logic        w2_valid;
    t_chan_set   w2_ch;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raster_format <= FMT_A1R5G5B5;
            r_cfg.palette_mode  <= PAL_DIRECT;
            r_cfg.alpha_present <= 1'b0;
            r_cfg.lane[0]       <= 3'd0;
            r_cfg.lane[1]       <= 3'd1;
            r_cfg.lane[2]       <= 3'd2;
            r_cfg.lane[3]       <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RASTER_FORMAT: r_cfg.raster_format <= i_cfg_data;
                CFG_PALETTE_MODE:  r_cfg.palette_mode  <= i_cfg_data[1:0];
                CFG_ALPHA_PRESENT: r_cfg.alpha_present <= i_cfg_data[0];
                CFG_RED_LANE:      r_cfg.lane[0]       <= i_cfg_data;
                CFG_GREEN_LANE:    r_cfg.lane[1]       <= i_cfg_data;
                CFG_BLUE_LANE:     r_cfg.lane[2]       <= i_cfg_data;
                CFG_ALPHA_LANE:    r_cfg.lane[3]       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves unless a finished beat waits at the output.
    assign w_adv    = !o_valid || i_ready;
    assign o_ready  = w_adv;
    assign w_accept = i_valid && o_ready;

    assign w_pal_sel = (r_cfg.palette_mode == PAL_IDX4) || (r_cfg.palette_mode == PAL_IDX8);
    assign w_idx     = (r_cfg.palette_mode == PAL_IDX4) ? {4'd0, i_in.texel_word[3:0]}
                                                         : i_in.texel_word[7:0];
    assign w_pal_we  = w_accept && (i_in.operation == OP_PAL_WRITE)
                       && ({1'b0, i_in.palette_slot} < DEPTH_LIM);

    tfu_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_waddr (i_in.palette_slot[AW-1:0]),
        .i_wdata (i_in.palette_word),
        .i_re    (w_adv),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // First stage: the palette read is in flight alongside these.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_accept && (i_in.operation == OP_CONVERT);
        end
        if (w_adv) begin
            r1_texel <= i_in.texel_word;
            r1_pal   <= w_pal_sel;
            r1_oor   <= ({1'b0, w_idx} >= DEPTH_LIM);
        end
    end

    tfu_chan_stage u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r1_valid),
        .i_texel (r1_texel),
        .i_pal   (r1_pal),
        .i_oor   (r1_oor),
        .i_rdata (w_rdata),
        .i_cfg   (r_cfg),
        .o_valid (w2_valid),
        .o_ch    (w2_ch)
    );

    tfu_lane_stage u_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w2_valid),
        .i_ch    (w2_ch),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // A palette write never turns into a result beat.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == OP_PAL_WRITE) |=> !r1_valid)
        else $error("palette write entered the result pipeline");

    // A converted texel always enters the pipeline.
    a_convert_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.operation == OP_CONVERT) |=> r1_valid)
        else $error("accepted texel was lost");

    // Back pressure is the only reason to refuse a beat.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused without output back pressure");

    // A lane that no channel wrote reads as zero.
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out.lanes_written[0] || o_out.lane_zero == 8'd0)
                  && (o_out.lanes_written[1] || o_out.lane_one == 8'd0)
                  && (o_out.lanes_written[2] || o_out.lane_two == 8'd0)
                  && (o_out.lanes_written[3] || o_out.lane_three == 8'd0)))
        else $error("unwritten lane carries data");

endmodule

// ===== dv/texel_format_unpacker_checker.sv =====
`timescale 1ns / 1ps

module texel_format_unpacker_checker
    import tfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_outstanding
);

    logic [2:0]  raster_fmt;
    logic [1:0]  pal_mode;
    logic        alpha_on;
    logic [2:0]  lane_of [4];
    logic [31:0] palette [256];
    t_out_item   pending_pixels [$];
    t_out_item   oldest;
    int          mismatch_count = 0;

    // Packed as alpha, blue, green, red so that element 0 is red.
    function automatic logic [3:0][31:0] format_masks(input logic [2:0] fmt);
        case (fmt)
            FMT_A1R5G5B5: return {32'h0000_0001, 32'h0000_F800, 32'h0000_07C0, 32'h0000_003E};
            FMT_B8G8R8:   return {32'h0000_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
            FMT_B8G8R8A8: return {32'hFF00_0000, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};
            FMT_R4G4B4A4: return {32'h0000_F000, 32'h0000_0F00, 32'h0000_00F0, 32'h0000_000F};
            FMT_R5G5B5:   return {32'h0000_0000, 32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F};
            FMT_R5G6B5:   return {32'h0000_0000, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F};
            FMT_LUM8:     return {32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF, 32'h0000_00FF};
            default:      return '0;
        endcase
    endfunction

    // Masks the channel and shifts it down to the lowest set mask bit.
    function automatic logic [7:0] pull_channel(input logic [31:0] pixel,
                                                input logic [31:0] mask);
        int pos;
        pos = 0;
        for (int b = 31; b >= 0; b--) begin
            if (mask[b]) pos = b;
        end
        return 8'((pixel & mask) >> pos);
    endfunction

    function automatic t_out_item convert_texel(input logic [31:0] texel);
        logic [3:0][31:0] masks;
        logic [31:0]      pixel;
        logic [7:0]       chan [4];
        logic [7:0]       bytes [4];
        logic [3:0]       written;
        t_out_item        r;
        masks = {32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF};
        if (pal_mode == PAL_IDX4) begin
            pixel = palette[texel[3:0]];
        end else if (pal_mode == PAL_IDX8) begin
            pixel = palette[texel[7:0]];
        end else begin
            pixel = texel;
            masks = format_masks(raster_fmt);
        end
        for (int c = 0; c < 3; c++) chan[c] = pull_channel(pixel, masks[c]);
        chan[3] = alpha_on ? pull_channel(pixel, masks[3]) : ALPHA_OPAQUE;
        written = '0;
        for (int c = 0; c < 4; c++) bytes[c] = 8'd0;
        // Channels are placed red first, so a later channel wins a shared lane.
        for (int c = 0; c < 4; c++) begin
            if (lane_of[c] <= 3'd3) begin
                bytes[lane_of[c][1:0]]   = chan[c];
                written[lane_of[c][1:0]] = 1'b1;
            end
        end
        r.lane_zero     = bytes[0];
        r.lane_one      = bytes[1];
        r.lane_two      = bytes[2];
        r.lane_three    = bytes[3];
        r.lanes_written = written;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("checker: %s at %0t ns", msg, $time);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            raster_fmt = FMT_A1R5G5B5;
            pal_mode   = PAL_DIRECT;
            alpha_on   = 1'b0;
            lane_of[0] = 3'd0;
            lane_of[1] = 3'd1;
            lane_of[2] = 3'd2;
            lane_of[3] = 3'd3;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RASTER_FORMAT: raster_fmt = i_cfg_data;
                    CFG_PALETTE_MODE:  pal_mode   = i_cfg_data[1:0];
                    CFG_ALPHA_PRESENT: alpha_on   = i_cfg_data[0];
                    CFG_RED_LANE:      lane_of[0] = i_cfg_data;
                    CFG_GREEN_LANE:    lane_of[1] = i_cfg_data;
                    CFG_BLUE_LANE:     lane_of[2] = i_cfg_data;
                    CFG_ALPHA_LANE:    lane_of[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in.operation == OP_PAL_WRITE) begin
                    palette[i_in.palette_slot] = i_in.palette_word;
                end else begin
                    pending_pixels.push_back(convert_texel(i_in.texel_word));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("result beat arrived with no texel outstanding");
                end else begin
                    oldest = pending_pixels.pop_front();
                    check_field("lane_zero", i_out.lane_zero, oldest.lane_zero);
                    check_field("lane_one", i_out.lane_one, oldest.lane_one);
                    check_field("lane_two", i_out.lane_two, oldest.lane_two);
                    check_field("lane_three", i_out.lane_three, oldest.lane_three);
                    check_field("lanes_written", 8'(i_out.lanes_written),
                                8'(oldest.lanes_written));
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_pixels.size();
    end

endmodule

// ===== dv/texel_format_unpacker_tb.sv =====
`timescale 1ns / 1ps

module texel_format_unpacker_tb;
    import tfu_pkg::*;

    localparam logic [2:0] FMT_NO_MASKS   = 3'd7;
    localparam logic [1:0] PAL_MODE_THREE = 2'd3;
    localparam logic [2:0] LANE_SKIP      = 3'b111;
    localparam int         HOLD_CYCLES    = 200;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_in;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_out;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [2:0] i_cfg_data;

    int          mismatches;
    int          outstanding;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [1:0]  cur_pal = PAL_DIRECT;
    logic [255:0] loaded = '0;
    int          texels_sent = 0;
    int          palette_loads = 0;
    int          settings_applied = 0;

    texel_format_unpacker i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    texel_format_unpacker_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in          (i_in),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out         (o_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Valid is left high after acceptance; the next beat either follows at once
    // or lowers it first.
    task automatic put_beat(input t_in_item beat);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_palette(input logic [7:0] slot, input logic [31:0] word);
        t_in_item beat;
        beat.operation    = OP_PAL_WRITE;
        beat.texel_word   = $urandom;
        beat.palette_slot = slot;
        beat.palette_word = word;
        loaded[slot] = 1'b1;
        palette_loads++;
        put_beat(beat);
    endtask

    // An entry that was never loaded is filled just before a texel reads it.
    task automatic send_texel(input logic [31:0] texel);
        t_in_item   beat;
        logic [7:0] idx;
        idx = (cur_pal == PAL_IDX4) ? {4'h0, texel[3:0]} : texel[7:0];
        if ((cur_pal == PAL_IDX4 || cur_pal == PAL_IDX8) && !loaded[idx]) begin
            send_palette(idx, $urandom);
        end
        beat.operation    = OP_CONVERT;
        beat.texel_word   = texel;
        beat.palette_slot = 8'($urandom);
        beat.palette_word = $urandom;
        texels_sent++;
        put_beat(beat);
    endtask

    // Palette loads give no result beat, so a few spare cycles let the
    // pipeline empty before the registers change.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [2:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [2:0] fmt, input logic [1:0] pal,
                                input logic alpha, input logic [2:0] red,
                                input logic [2:0] green, input logic [2:0] blue,
                                input logic [2:0] alpha_l);
        put_reg(CFG_RASTER_FORMAT, fmt);
        put_reg(CFG_PALETTE_MODE, {1'b0, pal});
        put_reg(CFG_ALPHA_PRESENT, {2'b00, alpha});
        put_reg(CFG_RED_LANE, red);
        put_reg(CFG_GREEN_LANE, green);
        put_reg(CFG_BLUE_LANE, blue);
        put_reg(CFG_ALPHA_LANE, alpha_l);
        i_cfg_we <= 1'b0;
        cur_pal = pal;
        settings_applied++;
    endtask

    // Mostly a real lane, now and then a value of 4 to 7 that writes nothing.
    function automatic logic [2:0] pick_lane();
        if ($urandom_range(0, 3) == 0) return 3'($urandom_range(4, 7));
        return 3'($urandom_range(0, 3));
    endfunction

    initial begin : result_sink
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [2:0]  fmt_pick;
        logic [1:0]  pal_pick;
        logic [31:0] texel;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset configuration.
        send_texel(32'h0000_0000);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h0000_AAAA);
        send_texel(32'h0000_5555);
        send_palette(8'd0, 32'h0000_0000);
        send_palette(8'd255, 32'hFFFF_FFFF);
        send_palette(8'd15, 32'h8040_2010);
        settle();
        // Empty masks, mode three as direct, shared lane, skipped and
        // out-of-range lanes.
        apply_config(FMT_NO_MASKS, PAL_MODE_THREE, 1'b1, 3'd3, 3'd3, LANE_SKIP, 3'd4);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h0000_0000);
        settle();
        // Alpha requested from a format that carries none.
        apply_config(FMT_B8G8R8, PAL_DIRECT, 1'b1, 3'd2, 3'd1, 3'd0, 3'd3);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h00AB_CDEF);
        settle();
        apply_config(FMT_LUM8, PAL_IDX8, 1'b1, 3'd0, 3'd1, 3'd2, 3'd3);
        send_texel(32'hFFFF_FF00);
        send_texel(32'h0000_00FF);
        settle();
        apply_config(FMT_R5G6B5, PAL_IDX4, 1'b0, 3'd3, 3'd2, 3'd1, 3'd0);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'hFFFF_FFF0);

        for (int phase = 0; phase < 14; phase++) begin
            settle();
            if (phase == 0) begin
                apply_config(FMT_NO_MASKS, PAL_MODE_THREE, 1'b1, 3'd3, 3'd3, 3'd3, 3'd3);
            end else if (phase == 1) begin
                apply_config(FMT_A1R5G5B5, PAL_DIRECT, 1'b0, LANE_SKIP, LANE_SKIP,
                             LANE_SKIP, LANE_SKIP);
            end else begin
                fmt_pick = 3'(phase);
                pal_pick = 2'($urandom_range(0, 3));
                apply_config(fmt_pick, pal_pick, 1'($urandom), pick_lane(), pick_lane(),
                             pick_lane(), pick_lane());
            end
            idle_on = (phase % 4 != 2);
            if (phase == 3 || phase == 9) begin
                // The sink holds off while beats keep coming, so the block backs up.
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_palette(8'($urandom_range(0, 255)), $urandom);
                end else begin
                    case ($urandom_range(0, 5))
                        0:       texel = {16'h0000, 16'($urandom)};
                        1:       texel = {8'h00, 24'($urandom)};
                        2:       texel = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                        default: texel = $urandom;
                    endcase
                    send_texel(texel);
                end
            end
        end
        settle();

        $display("Summary: %0d texel beats checked, %0d palette loads, %0d register settings.",
                 texels_sent, palette_loads, settings_applied);
        $display("Settings spanned every format and palette code, with shared and skipped lanes.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tfu_pkg.sv
sv/tfu_ram.sv
sv/tfu_chan_stage.sv
sv/tfu_lane_stage.sv
sv/texel_format_unpacker.sv
dv/texel_format_unpacker_checker.sv
dv/texel_format_unpacker_tb.sv
